>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is high.
`define MF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define MF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mf_pkg.sv
package mf_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_KERNEL = 2'd2
  } cfg_idx_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } mf_state_t;

  localparam int REG_W  = 11;
  localparam int KSZ_W  = 3;
  localparam int RANK_W = 6;   // holds up to 7 * 7 window samples

  // Commands from the sequencer to the rank selector.
  typedef struct packed {
    logic       start;
    logic       accum;
    logic       decide;
    logic [2:0] bit_idx;
  } rs_ctl_t;

endpackage

>>> hdl/mf_line_store.sv
module mf_line_store #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write one pixel.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/mf_rank_sel.sv
module mf_rank_sel (
  input  logic                      clk,
  input  mf_pkg::rs_ctl_t           ctl,
  input  logic [mf_pkg::RANK_W-1:0] mid,
  input  logic [7:0]                sample,
  output logic [7:0]                result
);
  import mf_pkg::*;

  logic [7:0]        prefix;
  logic [RANK_W-1:0] rank;
  logic [RANK_W-1:0] cnt;
  logic [7:0]        hi_mask;
  logic              match;
  logic [RANK_W-1:0] total;

  // Sample agrees with the decided upper bits and has a zero at the current bit.
  always_comb begin
    hi_mask = 8'hFF << (ctl.bit_idx + 4'd1);
    match   = (((sample ^ prefix) & hi_mask) == 8'd0) && !sample[ctl.bit_idx];
    total   = cnt + ((ctl.accum && match) ? RANK_W'(1) : RANK_W'(0));
  end

  // Radix select: settle one bit of the median per pass.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prefix <= 8'd0;
      rank   <= mid;
      cnt    <= '0;
    end else if (ctl.decide) begin
      cnt <= '0;
      if (rank >= total) begin
        rank                 <= rank - total;
        prefix[ctl.bit_idx]  <= 1'b1;
      end
    end else if (ctl.accum) begin
      cnt <= total;
    end
  end

  assign result = prefix;

endmodule

>>> hdl/median_filter_2d.sv
// Streaming k x k median filter, zero padded, 8-bit grayscale.
// Pixel channel: pix_valid/pix_stall with kind and pixel; kind 1 is a flush tick.
// Result channel: res_valid/res_stall with median, row_end and frame_end.
// Config channel: cfg_valid/cfg_ready, cfg_index selects width, height or kernel
// size; a write restarts the frame. Write only while the block is idle.
// Pixels are written to a line store of MAX_KERNEL rows; each output rereads
// its window from that store through its single read port and finds the
// median one bit per pass. A request frees up to four outputs for a pixel
// and one for a flush, all computed before the next request is taken.
// Results leave in raster order, each once its window's last in-image pixel
// has arrived.
// The result register frees the pixel side: a new request is taken while a
// finished result still waits. While the receiver stalls with a result
// waiting and another one is ready, the sequencer holds and takes no request.
// Reset clears positions and sets width 1024, height 1024, kernel 3; the
// line store is not cleared, it is always written before read.
module median_filter_2d #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  logic                      kind,
  input  logic [7:0]                pixel,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [7:0]                median,
  output logic                      row_end,
  output logic                      frame_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [mf_pkg::REG_W-1:0]  cfg_data
);
  import mf_pkg::*;

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SB    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [REG_W-1:0] image_width, image_height;
  logic [KSZ_W-1:0] kernel_size;

  // Clamped working geometry.
  logic [WB-1:0]    w;
  logic [HB-1:0]    h;
  logic [KSZ_W-1:0] k, r, d;

  always_comb begin
    if (image_width == '0)                          w = WB'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH))     w = WB'(MAX_WIDTH);
    else                                            w = WB'(image_width);
    if (image_height == '0)                         h = HB'(1);
    else if (32'(image_height) > 32'(MAX_HEIGHT))   h = HB'(MAX_HEIGHT);
    else                                            h = HB'(image_height);
    if (kernel_size == '0)                          k = KSZ_W'(1);
    else if (32'(kernel_size) > 32'(MAX_KERNEL))    k = KSZ_W'(MAX_KERNEL);
    else                                            k = kernel_size;
    r = k >> 1;
    d = k - KSZ_W'(1) - r;
  end

  // Positions.
  logic [HB-1:0] in_row, out_row;
  logic [WB-1:0] in_col, out_col;
  logic [SB-1:0] in_slot, out_slot;

  mf_state_t state, state_next;
  logic [2:0] cap, n_out;
  logic [KSZ_W-1:0] wm, wn;
  logic [SB-1:0] ws;
  logic [2:0] bit_idx;
  logic smp_v, smp_pad;

  // Output readiness of the next result.
  logic [HB:0] ly;
  logic [WB:0] lx;
  logic        out_ready, owed;

  always_comb begin
    ly = (HB+1)'(out_row) + (HB+1)'(d);
    if (ly > (HB+1)'(h) - (HB+1)'(1)) ly = (HB+1)'(h) - (HB+1)'(1);
    lx = (WB+1)'(out_col) + (WB+1)'(d);
    if (lx > (WB+1)'(w) - (WB+1)'(1)) lx = (WB+1)'(w) - (WB+1)'(1);
    out_ready = (ly < (HB+1)'(in_row)) ||
                ((ly == (HB+1)'(in_row)) && (lx < (WB+1)'(in_col)));
    owed = (n_out < cap) && (out_row < h) && out_ready;
  end

  // Window sample coordinates.
  logic [HB:0] ysum;
  logic [WB:0] xsum, xcol;
  logic        in_img, last_smp, rend, fend, emit_go;
  logic [SB:0] ws_start;

  always_comb begin
    ysum   = (HB+1)'(out_row) + (HB+1)'(wm);
    xsum   = (WB+1)'(out_col) + (WB+1)'(wn);
    xcol   = xsum - (WB+1)'(r);
    in_img = (ysum >= (HB+1)'(r)) && ((ysum - (HB+1)'(r)) < (HB+1)'(h)) &&
             (xsum >= (WB+1)'(r)) && (xcol < (WB+1)'(w));
    last_smp = (wm == k - KSZ_W'(1)) && (wn == k - KSZ_W'(1));
    ws_start = (SB+1)'(out_slot) + (SB+1)'(MAX_KERNEL) - (SB+1)'(r);
    if (ws_start >= (SB+1)'(MAX_KERNEL)) ws_start = ws_start - (SB+1)'(MAX_KERNEL);
    rend    = out_col == w - WB'(1);
    fend    = rend && (out_row == h - HB'(1));
    emit_go = !res_valid || !res_stall;
  end

  // Line store.
  logic          st_wr;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_rdata;
  logic          pix_take, pix_write;

  assign pix_take  = pix_valid && !pix_stall;
  assign pix_write = pix_take && !kind && (in_row < h);
  assign st_wr     = pix_write;
  assign st_waddr  = AW'(in_slot * MAX_WIDTH) + AW'(in_col[CB-1:0]);
  assign st_raddr  = AW'(ws * MAX_WIDTH) + AW'(xcol[CB-1:0]);

  mf_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr (st_waddr),
    .wr_data (pixel),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  // Rank selector.
  rs_ctl_t           rs_ctl;
  logic [RANK_W-1:0] mid;
  logic [7:0]        sel;

  assign mid = (RANK_W'(k) * RANK_W'(k)) >> 1;

  mf_rank_sel u_sel (
    .clk    (clk),
    .ctl    (rs_ctl),
    .mid    (mid),
    .sample (smp_pad ? st_rdata : 8'd0),
    .result (sel)
  );

  // Sequencer next state and strobes.
  always_comb begin
    state_next     = state;
    pix_stall      = 1'b1;
    rs_ctl.start   = 1'b0;
    rs_ctl.accum   = smp_v;
    rs_ctl.decide  = 1'b0;
    rs_ctl.bit_idx = bit_idx;
    case (state)
      ST_IDLE: begin
        pix_stall = 1'b0;
        if (pix_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (owed) begin
          rs_ctl.start = 1'b1;
          state_next   = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (last_smp) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        rs_ctl.decide = 1'b1;
        state_next    = (bit_idx == 3'd0) ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        if (emit_go) state_next = fend ? ST_IDLE : ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Window scan counters and read pipeline flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_v <= 1'b0;
    end else begin
      smp_v <= (state == ST_SCAN);
    end
    smp_pad <= in_img;
    if (state == ST_CHECK || (state == ST_DECIDE && bit_idx != 3'd0)) begin
      wm <= '0;
      wn <= '0;
      ws <= SB'(ws_start);
    end else if (state == ST_SCAN) begin
      if (wn == k - KSZ_W'(1)) begin
        wn <= '0;
        wm <= wm + KSZ_W'(1);
        ws <= (ws == SB'(MAX_KERNEL - 1)) ? '0 : ws + SB'(1);
      end else begin
        wn <= wn + KSZ_W'(1);
      end
    end
    if (state == ST_CHECK)       bit_idx <= 3'd7;
    else if (state == ST_DECIDE) bit_idx <= bit_idx - 3'd1;
  end

  // Registers, positions and the result register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= REG_W'(1024);
      image_height <= REG_W'(1024);
      kernel_size  <= KSZ_W'(3);
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
      cap <= 3'd1; n_out <= 3'd0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  image_width  <= cfg_data;
          CFG_HEIGHT: image_height <= cfg_data;
          CFG_KERNEL: kernel_size  <= cfg_data[KSZ_W-1:0];
          default: ;
        endcase
        if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
            cfg_index == CFG_KERNEL) begin
          in_row <= '0; in_col <= '0; in_slot <= '0;
          out_row <= '0; out_col <= '0; out_slot <= '0;
        end
      end
      // Take a request: store an in-image pixel and advance the input position.
      if (pix_take) begin
        n_out <= 3'd0;
        cap   <= pix_write ? 3'd4 : 3'd1;
        if (pix_write) begin
          if (in_col == w - WB'(1)) begin
            in_col  <= '0;
            in_row  <= in_row + HB'(1);
            in_slot <= (in_slot == SB'(MAX_KERNEL - 1)) ? '0 : in_slot + SB'(1);
          end else begin
            in_col <= in_col + WB'(1);
          end
        end
      end
      // Emit a result and advance the output position, or clear all positions after the frame's last one.
      if (state == ST_EMIT && emit_go) begin
        res_valid <= 1'b1;
        n_out     <= n_out + 3'd1;
        if (fend) begin
          in_row <= '0; in_col <= '0; in_slot <= '0;
          out_row <= '0; out_col <= '0; out_slot <= '0;
        end else if (rend) begin
          out_col  <= '0;
          out_row  <= out_row + HB'(1);
          out_slot <= (out_slot == SB'(MAX_KERNEL - 1)) ? '0 : out_slot + SB'(1);
        end else begin
          out_col <= out_col + WB'(1);
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_go) begin
      median    <= sel;
      row_end   <= rend;
      frame_end <= fend;
    end
  end

endmodule

>>> hdl/mf_checker.sv
`include "assert_macros.svh"

module mf_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] median,
  input logic       row_end,
  input logic       frame_end
);

  // Hold a stalled result.
  `MF_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid, "result dropped under stall")
  `MF_ASSERT(a_res_stable, clk, rst, res_valid && res_stall |=> $stable(median) && $stable(frame_end), "stalled result changed")
  // The frame's last result also closes its row.
  `MF_ASSERT(a_frame_row, clk, rst, res_valid && frame_end |-> row_end, "frame end without row end")
  // No result right after reset.
  `MF_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !res_valid, "result after reset")

endmodule

bind median_filter_2d mf_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .median    (median),
  .row_end   (row_end),
  .frame_end (frame_end)
);
